[rtl/wcmp_pkg.sv]
// Shared widths, register map, reset values and types for the waveform column min/peak block.
package wcmp_pkg;

  // Field widths
  localparam int SAMPLE_W      = 16;
  localparam int HEIGHT_W      = 12;
  localparam int AMP_W         = 15;
  localparam int SPC_W         = 16;
  localparam int COL_TOTAL_W   = 13;
  localparam int COL_IDX_W     = 12;
  localparam int VALUE_W       = 12;

  // Column count limit of one pass
  localparam int MAX_COLUMNS_DEFAULT = 4096;

  // Register port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Scaling datapath
  localparam int PROD_W    = 32;              // signed sample times amplitude
  localparam int X8_W      = 8 + AMP_W;       // 8-bit sample times amplitude
  localparam int NUM8_W    = X8_W + 1;        // reciprocal sum for the divide by 255
  localparam int QUOT_W    = 17;              // signed quotient
  localparam int DISP_W    = 18;              // signed display value before clamp
  localparam int DIV8      = 255;             // 8-bit full scale divisor
  localparam int Q16_DIV   = 32768;           // 16-bit full scale divisor
  localparam int Q16_SHIFT = $clog2(Q16_DIV);

  // Reset values
  localparam logic                   MODE_RST      = 1'b1;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RST    = 12'd255;
  localparam logic [AMP_W-1:0]       AMP_RST       = 15'd255;
  localparam logic [SPC_W-1:0]       SPC_RST       = 16'd1;
  localparam logic [COL_TOTAL_W-1:0] COL_TOTAL_RST = 13'd1024;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_SIXTEEN_BIT_MODE,
    REG_HEIGHT,
    REG_AMPLITUDE,
    REG_SAMPLES_PER_COLUMN,
    REG_COLUMN_TOTAL
  } reg_idx_t;

  // Settings that the scaling pipeline needs
  typedef struct packed {
    logic                sixteen_bit_mode;
    logic [HEIGHT_W-1:0] height;
    logic [AMP_W-1:0]    amplitude;
  } scale_cfg_t;

endpackage

[rtl/wcmp_if.sv]
// Valid/ready channel interfaces for the sample input and the column result output.
interface wcmp_sample_if import wcmp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wcmp_column_if import wcmp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_IDX_W-1:0] column_index;
  logic [VALUE_W-1:0]   column_min;
  logic [VALUE_W-1:0]   column_peak;
  logic                 last_column;

  modport source (output valid, output column_index, output column_min, output column_peak,
                  output last_column, input ready);
  modport sink (input valid, input column_index, input column_min, input column_peak,
                input last_column, output ready);
endinterface

[rtl/wcmp_scale.sv]
// Three-stage pipeline that turns a raw sample into a signed, unclamped display value.
module wcmp_scale import wcmp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  scale_cfg_t               cfg,
  wcmp_sample_if.sink              samples,
  output logic                     value_valid,
  input  logic                     value_ready,
  output logic signed [DISP_W-1:0] value
);

  localparam int AEXT_W = SAMPLE_W + 1;

  // Stage valids and load enables
  logic v1, v2, v3;
  logic ld1, ld2, ld3;

  // Stage 1: product
  logic signed [AEXT_W-1:0]       a_op;
  logic signed [AMP_W:0]          b_op;
  logic signed [AEXT_W+AMP_W:0]   prod_full;
  logic signed [PROD_W-1:0]       prod;
  logic                           mode1;

  // Stage 2: quotient estimate
  logic [X8_W-1:0]                x8;
  logic [NUM8_W-1:0]              num8;
  logic [PROD_W-1:0]              biased;
  logic [QUOT_W-1:0]              q16;
  logic [QUOT_W-1:0]              q_est;
  logic [QUOT_W-1:0]              q2_reg;
  logic [X8_W-1:0]                x2;
  logic                           mode2;

  // Stage 3: correction and offset
  logic [NUM8_W-1:0]              rem8;
  logic                           corr;
  logic [QUOT_W-1:0]              q_fix;
  logic [HEIGHT_W-1:0]            base;
  logic signed [DISP_W-1:0]       base_s;
  logic signed [DISP_W-1:0]       q_s;

  // Advance a stage when the next one is empty or moving
  assign ld3 = !v3 || value_ready;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign samples.ready = ld1;
  assign value_valid   = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= samples.valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  // Stage 1: one signed multiply covers both sample formats
  always_comb begin
    if (cfg.sixteen_bit_mode) begin
      a_op = $signed({samples.sample[SAMPLE_W-1], samples.sample});
    end else begin
      a_op = $signed({{(AEXT_W-8){1'b0}}, samples.sample[7:0]});
    end
    b_op      = $signed({1'b0, cfg.amplitude});
    prod_full = a_op * b_op;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      prod  <= prod_full[PROD_W-1:0];
      mode1 <= cfg.sixteen_bit_mode;
    end
  end

  // Stage 2: divide by 32768 toward zero, or estimate the divide by 255
  always_comb begin
    x8     = prod[X8_W-1:0];
    num8   = NUM8_W'(x8) + NUM8_W'(x8 >> 8) + NUM8_W'(x8 >> 16);
    biased = prod[PROD_W-1] ? (prod + PROD_W'(Q16_DIV - 1)) : prod;
    q16    = biased[Q16_SHIFT +: QUOT_W];
    q_est  = mode1 ? q16 : QUOT_W'(num8[NUM8_W-1:8]);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      q2_reg <= q_est;
      x2     <= x8;
      mode2  <= mode1;
    end
  end

  // Stage 3: fix the 255 estimate (it may be one low), then offset from the baseline
  always_comb begin
    rem8   = NUM8_W'(x2) + NUM8_W'(q2_reg) - {q2_reg[NUM8_W-9:0], 8'b0};
    corr   = !mode2 && (rem8 >= NUM8_W'(DIV8));
    q_fix  = q2_reg + QUOT_W'(corr);
    base   = mode2 ? (cfg.height >> 1) : cfg.height;
    base_s = $signed({{(DISP_W-HEIGHT_W){1'b0}}, base});
    q_s    = $signed({{(DISP_W-QUOT_W){q_fix[QUOT_W-1]}}, q_fix});
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      value <= base_s - q_s;
    end
  end

  // A held result stays in place until taken
  a_hold_value: assert property (@(posedge clk) disable iff (rst)
    (v3 && !value_ready) |=> (v3 && $stable(value)))
    else $error("scale output changed while stalled");

  // A stalled stage 2 item is not lost
  a_hold_stage2: assert property (@(posedge clk) disable iff (rst)
    (v2 && !ld2) |=> v2)
    else $error("stage 2 item dropped");

  // An accepted sample reaches stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> v1)
    else $error("accepted sample lost");

endmodule

[rtl/waveform_column_min_peak.sv]
// Min/peak decimation of a mono sample stream into display columns: top level.
// Path: the sample that completes a column goes through multiply, divide estimate and correction,
// then clamp and column accumulate, each registered, before its result shows.
// Throughput: one sample per cycle; the product, the divide estimate, its correction and the
// accumulate each take one registered stage, so only a held result with a full pipeline stops input.
// Reset: settings return to their defaults, counters clear, no result is pending.
module waveform_column_min_peak import wcmp_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  wcmp_sample_if.sink        samples,
  wcmp_column_if.source      columns
);

  localparam int CntW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CmpW = (CntW + 1 > COL_TOTAL_W) ? CntW + 1 : COL_TOTAL_W;

  // Settings
  logic                   sixteen_bit_mode;
  logic [HEIGHT_W-1:0]    height;
  logic [AMP_W-1:0]       amplitude;
  logic [SPC_W-1:0]       samples_per_column;
  logic [COL_TOTAL_W-1:0] column_total;
  reg_idx_t               reg_idx;
  logic                   wr;
  scale_cfg_t             cfg;

  // Scaling pipeline output
  logic                     value_valid;
  logic                     value_ready;
  logic signed [DISP_W-1:0] value;

  // Column state
  logic [VALUE_W-1:0] running_min;
  logic [VALUE_W-1:0] running_peak;
  logic [SPC_W-1:0]   sample_in_column;
  logic [CntW-1:0]    column_counter;

  logic               fire;
  logic [VALUE_W-1:0] clamped;
  logic [VALUE_W-1:0] eff_min;
  logic [VALUE_W-1:0] eff_peak;
  logic [VALUE_W-1:0] running_min_next;
  logic [VALUE_W-1:0] running_peak_next;
  logic [SPC_W-1:0]   sample_in_column_next;
  logic               col_done;
  logic [CntW:0]      col_next;
  logic               last;

  // Register port
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sixteen_bit_mode   <= MODE_RST;
      height             <= HEIGHT_RST;
      amplitude          <= AMP_RST;
      samples_per_column <= SPC_RST;
      column_total       <= COL_TOTAL_RST;
    end else if (wr) begin
      unique case (reg_idx)
        REG_SIXTEEN_BIT_MODE:   sixteen_bit_mode   <= pwdata[0];
        REG_HEIGHT:             height             <= pwdata[HEIGHT_W-1:0];
        REG_AMPLITUDE:          amplitude          <= pwdata[AMP_W-1:0];
        REG_SAMPLES_PER_COLUMN: samples_per_column <= pwdata[SPC_W-1:0];
        REG_COLUMN_TOTAL:       column_total       <= pwdata[COL_TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIXTEEN_BIT_MODE:   prdata = PDATA_W'(sixteen_bit_mode);
      REG_HEIGHT:             prdata = PDATA_W'(height);
      REG_AMPLITUDE:          prdata = PDATA_W'(amplitude);
      REG_SAMPLES_PER_COLUMN: prdata = PDATA_W'(samples_per_column);
      REG_COLUMN_TOTAL:       prdata = PDATA_W'(column_total);
      default:                prdata = '0;
    endcase
  end

  // Sample to display value
  assign cfg = '{sixteen_bit_mode: sixteen_bit_mode, height: height, amplitude: amplitude};

  wcmp_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .samples     (samples),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value)
  );

  // Take a value whenever the result register is free
  assign value_ready = !columns.valid || columns.ready;
  assign fire        = value_valid && value_ready;

  // Clamp, then fold into the column min and peak
  always_comb begin
    if (value[DISP_W-1]) begin
      clamped = '0;
    end else if (value > $signed({{(DISP_W-HEIGHT_W){1'b0}}, height})) begin
      clamped = height;
    end else begin
      clamped = value[VALUE_W-1:0];
    end
    eff_min  = (sample_in_column == '0) ? height : running_min;
    eff_peak = (sample_in_column == '0) ? '0 : running_peak;
    running_min_next      = (clamped < eff_min) ? clamped : eff_min;
    running_peak_next     = (clamped > eff_peak) ? clamped : eff_peak;
    sample_in_column_next = sample_in_column + 1'b1;
    col_done = (sample_in_column_next == samples_per_column);
    col_next = {1'b0, column_counter} + 1'b1;
    last     = (CmpW'(col_next) == CmpW'(column_total)) ||
               (col_next == (CntW+1)'(MAX_COLUMNS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_in_column <= '0;
      column_counter   <= '0;
    end else if (fire) begin
      if (col_done) begin
        sample_in_column <= '0;
        column_counter   <= last ? '0 : col_next[CntW-1:0];
      end else begin
        sample_in_column <= sample_in_column_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      running_min  <= running_min_next;
      running_peak <= running_peak_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      columns.valid <= 1'b0;
    end else if (fire && col_done) begin
      columns.valid <= 1'b1;
    end else if (columns.ready) begin
      columns.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && col_done) begin
      columns.column_index <= COL_IDX_W'(column_counter);
      columns.column_min   <= running_min_next;
      columns.column_peak  <= running_peak_next;
      columns.last_column  <= last;
    end
  end

  // Every column holds at least one sample, so min never exceeds peak
  a_min_le_peak: assert property (@(posedge clk) disable iff (rst)
    columns.valid |-> (columns.column_min <= columns.column_peak))
    else $error("column min above column peak");

  // The final column of a pass wraps the column counter
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (fire && col_done && last) |=> (column_counter == '0))
    else $error("column counter did not wrap after last column");

  // A value inside a column advances the sample count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (fire && !col_done) |=> (sample_in_column == $past(sample_in_column_next)))
    else $error("sample count did not advance");

  // A finished column always produces a pending result
  a_column_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && col_done) |=> columns.valid)
    else $error("finished column produced no result");

endmodule

[test/tb_waveform_column_min_peak.sv]
// Testbench for the waveform column min/peak block: random and directed samples, checked per column.
`timescale 1ns / 1ps

module tb_waveform_column_min_peak;
  import wcmp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;

  // Expected columns: tracks the block's settings and running state, queues each column result
  class column_scoreboard;
    typedef struct {
      logic [COL_IDX_W-1:0] index;
      logic [VALUE_W-1:0]   lo;
      logic [VALUE_W-1:0]   hi;
      logic                 last;
    } column_t;

    logic                   mode;
    logic [HEIGHT_W-1:0]    height;
    logic [AMP_W-1:0]       amplitude;
    logic [SPC_W-1:0]       spc;
    logic [COL_TOTAL_W-1:0] col_total;
    logic [VALUE_W-1:0]     run_min;
    logic [VALUE_W-1:0]     run_peak;
    logic [SPC_W-1:0]       sample_count;
    logic [COL_IDX_W-1:0]   column_count;
    column_t                expected_columns[$];
    int                     mismatches;

    function new();
      mode         = MODE_RST;
      height       = HEIGHT_RST;
      amplitude    = AMP_RST;
      spc          = SPC_RST;
      col_total    = COL_TOTAL_RST;
      run_min      = HEIGHT_RST;
      run_peak     = '0;
      sample_count = '0;
      column_count = '0;
      mismatches   = 0;
    endfunction

    function void write_setting(reg_idx_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_SIXTEEN_BIT_MODE:   mode      = value[0];
        REG_HEIGHT:             height    = value[HEIGHT_W-1:0];
        REG_AMPLITUDE:          amplitude = value[AMP_W-1:0];
        REG_SAMPLES_PER_COLUMN: spc       = value[SPC_W-1:0];
        REG_COLUMN_TOTAL:       col_total = value[COL_TOTAL_W-1:0];
        default: ;
      endcase
    endfunction

    // Scale one raw sample to a clamped display row
    function logic [VALUE_W-1:0] pixel_of(logic [SAMPLE_W-1:0] raw);
      longint h;
      longint a;
      longint s;
      longint v;
      h = height;
      a = amplitude;
      if (mode) begin
        s = $signed(raw);
        v = h / 2 - (s * a) / Q16_DIV;
      end else begin
        s = raw[7:0];
        v = h - (s * a) / DIV8;
      end
      if (v > h) v = h;
      if (v < 0) v = 0;
      return v[VALUE_W-1:0];
    endfunction

    // Fold one accepted sample into the column; queue a result when the column closes
    function void note_sample(logic [SAMPLE_W-1:0] raw);
      logic [VALUE_W-1:0] px;
      logic [SPC_W-1:0]   next_count;
      int unsigned        col_next;
      column_t            c;
      px = pixel_of(raw);
      if (sample_count == 0) begin
        run_min  = height;
        run_peak = '0;
      end
      if (px < run_min) run_min = px;
      if (px > run_peak) run_peak = px;
      next_count = sample_count + 1'b1;
      if (next_count != spc) begin
        sample_count = next_count;
        return;
      end
      col_next = column_count + 1;
      c.index  = column_count;
      c.lo     = run_min;
      c.hi     = run_peak;
      c.last   = (col_next == col_total) || (col_next >= MAX_COLUMNS_DEFAULT);
      expected_columns.push_back(c);
      column_count = c.last ? '0 : col_next[COL_IDX_W-1:0];
      sample_count = '0;
      run_min      = height;
      run_peak     = '0;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Compare one delivered column with the oldest expected one
    task check_column(logic [COL_IDX_W-1:0] index, logic [VALUE_W-1:0] lo,
                      logic [VALUE_W-1:0] hi, logic last);
      column_t e;
      if (expected_columns.size() == 0) begin
        report($sformatf("unexpected column %0d min %0d peak %0d", index, lo, hi));
        return;
      end
      e = expected_columns.pop_front();
      if (index !== e.index)
        report($sformatf("column_index %0d, want %0d", index, e.index));
      if (lo !== e.lo)
        report($sformatf("column %0d column_min %0d, want %0d", e.index, lo, e.lo));
      if (hi !== e.hi)
        report($sformatf("column %0d column_peak %0d, want %0d", e.index, hi, e.hi));
      if (last !== e.last)
        report($sformatf("column %0d last_column %0b, want %0b", e.index, last, e.last));
    endtask

    function int pending();
      return expected_columns.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               hold_req;
  int                 send_idle;
  int                 recv_idle;
  int                 cycle_count = 0;

  column_scoreboard sb = new();

  wcmp_sample_if sample_ch ();
  wcmp_column_if column_ch ();

  waveform_column_min_peak DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (sample_ch),
    .columns (column_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_waveform_column_min_peak NOT OK");
      $finish;
    end
  end

  // Check every accepted column request
  always @(posedge clk) begin
    if (!rst && column_ch.valid && column_ch.ready)
      sb.check_column(column_ch.column_index, column_ch.column_min, column_ch.column_peak,
                      column_ch.last_column);
  end

  // Drive result ready: random stalls, or a long hold on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        column_ch.ready <= 1'b0;
        for (held = 1; held < LONG_HOLD; held++) begin
          @(posedge clk);
          column_ch.ready <= 1'b0;
        end
      end else begin
        column_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h00FF;
      5: return 16'h0080;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one sample request and hold it until accepted
  task automatic push_sample(logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      sample_ch.valid  <= 1'b0;
      sample_ch.sample <= SAMPLE_W'($urandom);
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_sample(value);
  endtask

  // Drop valid and wait until every expected column is out and the pipeline is empty
  task automatic settle_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_setting(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Pick new settings; column shape stays put when a column is half done
  task automatic apply_random_settings(bit keep_column);
    logic [HEIGHT_W-1:0] h;
    logic [AMP_W-1:0]    a;
    case ($urandom_range(3))
      0:       h = '0;
      1:       h = 12'd4095;
      default: h = HEIGHT_W'($urandom_range(4095));
    endcase
    case ($urandom_range(5))
      0:       a = '0;
      1:       a = 15'd32767;
      2:       a = AMP_W'(h);
      3:       a = AMP_W'(h / 2);
      default: a = AMP_W'($urandom_range(32767));
    endcase
    write_register(REG_SIXTEEN_BIT_MODE, $urandom_range(1));
    write_register(REG_HEIGHT, h);
    write_register(REG_AMPLITUDE, a);
    if (!keep_column) begin
      write_register(REG_SAMPLES_PER_COLUMN, $urandom_range(1, 8));
      case ($urandom_range(4))
        0:       write_register(REG_COLUMN_TOTAL, 1);
        1:       write_register(REG_COLUMN_TOTAL, 8191);
        default: write_register(REG_COLUMN_TOTAL, $urandom_range(2, 12));
      endcase
    end
  endtask

  // One random phase; optionally pad to a column boundary
  task automatic run_phase(int count, bit aligned);
    int k;
    apply_random_settings(sb.sample_count != 0);
    for (k = 0; k < count; k++) push_sample(pick_sample());
    if (aligned)
      while (sb.sample_count != 0) push_sample(pick_sample());
    settle_idle();
  endtask

  initial begin
    int grp;
    int ph;
    int k;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    hold_req         = 1'b0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    column_ch.ready  = 1'b0;
    send_idle        = 0;
    recv_idle        = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults: signed extremes, one column each
    push_sample(16'h0000);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'hFFFF);
    settle_idle();

    // Unsigned mode at full height and amplitude; ignored high byte; end of pass wraps
    write_register(REG_SIXTEEN_BIT_MODE, 0);
    write_register(REG_HEIGHT, 4095);
    write_register(REG_AMPLITUDE, 32767);
    write_register(REG_SAMPLES_PER_COLUMN, 2);
    write_register(REG_COLUMN_TOTAL, 3);
    push_sample(16'h0000);
    push_sample(16'h00FF);
    push_sample(16'hFF00);
    push_sample(16'h0080);
    push_sample(16'h0001);
    push_sample(16'hFFFE);
    settle_idle();

    // Zero height clamps everything to the top row
    write_register(REG_HEIGHT, 0);
    push_sample(16'h1234);
    push_sample(16'h00FF);
    settle_idle();

    // Height lowered partway through a column keeps the gathered min and peak
    write_register(REG_HEIGHT, 100);
    write_register(REG_AMPLITUDE, 100);
    write_register(REG_SAMPLES_PER_COLUMN, 4);
    push_sample(16'h0000);
    push_sample(16'h0010);
    settle_idle();
    write_register(REG_HEIGHT, 50);
    push_sample(16'h0000);
    push_sample(16'h00FF);
    settle_idle();

    // Height set before a column's first sample becomes its starting min
    write_register(REG_HEIGHT, 30);
    write_register(REG_AMPLITUDE, 0);
    write_register(REG_COLUMN_TOTAL, 1);
    for (k = 0; k < 4; k++) push_sample(16'h00FF);
    settle_idle();

    // Random phases under three idling patterns
    for (grp = 0; grp < 3; grp++) begin
      case (grp)
        0: begin send_idle = 33; recv_idle = 58; end
        1: begin send_idle = 58; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (ph = 0; ph < 8; ph++) run_phase($urandom_range(35, 85), (ph % 3) != 2);
    end

    // Back up the pipeline behind a long result stall
    write_register(REG_SAMPLES_PER_COLUMN, 1);
    write_register(REG_COLUMN_TOTAL, 1024);
    hold_req <= 1'b1;
    for (k = 0; k < 100; k++) push_sample(pick_sample());
    settle_idle();

    // Zero column total: columns run on without a last flag short of the column limit
    write_register(REG_COLUMN_TOTAL, 0);
    for (k = 0; k < 60; k++) push_sample(pick_sample());
    settle_idle();

    // Zero samples per column: the sample counter runs on and no column closes
    write_register(REG_SAMPLES_PER_COLUMN, 0);
    for (k = 0; k < 20; k++) push_sample(pick_sample());
    settle_idle();

    repeat (12) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_waveform_column_min_peak OK");
    end else begin
      $display("tb_waveform_column_min_peak NOT OK");
    end
    $finish;
  end

endmodule
